// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the online mean and scatter unit.
// Depends on nothing; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OMSU_ASSERT_IMPL(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle implication failed");
`define OMSU_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle implication failed");
`else
`define OMSU_ASSERT_IMPL(lbl, clk, rst, a, b)
`define OMSU_ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

// ===== rtl/omsu_pkg.sv =====
// Shared constants and controller/datapath interface types for the
// online mean and scatter unit. Depends on nothing.
package omsu_pkg;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam int SMP_W = 32;
  localparam int SCT_W = 64;
  localparam int CNT_W = 32;
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 34;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic latch_diff;
    logic scat_mul;
    logic scat_div;
    logic scat_upd;
    logic mean_div;
    logic mean_upd;
    logic count_inc;
    logic rd_div;
    logic rd_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_push;
    logic is_read;
    logic read_ok;
    logic scat_last;
    logic mean_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/omsu_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on omsu_pkg for the operand widths.
module omsu_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [omsu_pkg::DIV_NW-1:0]    dividend,
  input  logic [omsu_pkg::DIV_DW-1:0]    divisor,
  output logic [omsu_pkg::DIV_NW-1:0]    quotient,
  output logic [omsu_pkg::DIV_DW-1:0]    remainder,
  output logic                           done
);

  localparam int CW = $clog2(omsu_pkg::DIV_NW);

  logic                          busy;
  logic [CW-1:0]                 cnt;
  logic [omsu_pkg::DIV_DW-1:0]   rem;
  logic [omsu_pkg::DIV_NW-1:0]   quot;
  logic [omsu_pkg::DIV_DW-1:0]   dvs;
  logic [omsu_pkg::DIV_DW:0]     trial;
  logic                          ge;

  assign trial = {rem, quot[omsu_pkg::DIV_NW-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(omsu_pkg::DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= ge ? omsu_pkg::DIV_DW'(trial - {1'b0, dvs}) : trial[omsu_pkg::DIV_DW-1:0];
      quot <= {quot[omsu_pkg::DIV_NW-2:0], ge};
    end
  end

  assign quotient  = quot;
  assign remainder = rem;

endmodule

// ===== rtl/omsu_dp.sv =====
// Datapath: sample buffer, mean, scatter memory, multiplier, divider and
// output register. Depends on omsu_pkg and omsu_div.
module omsu_dp #(
  parameter int DIM = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  omsu_pkg::cmd_t       cmd,
  output omsu_pkg::sts_t       sts,
  input  logic [1:0]           mode,
  input  logic [2:0]           element_index,
  input  logic signed [31:0]   element_value,
  input  logic [2:0]           row,
  input  logic [2:0]           col,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [63:0]   variance_value,
  output logic                 variance_valid
);

  localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int MD = DIM * DIM;
  localparam int AW = (MD > 1) ? $clog2(MD) : 1;
  localparam int SW = omsu_pkg::SMP_W;
  localparam int LW = omsu_pkg::SCT_W;
  localparam int CW = omsu_pkg::CNT_W;
  localparam int NW = omsu_pkg::DIV_NW;
  localparam int DW = omsu_pkg::DIV_DW;

  logic signed [SW-1:0] sample_buf [DIM];
  logic signed [SW-1:0] mean [DIM];
  logic signed [SW:0]   diff [DIM];
  logic [CW-1:0]        count;
  logic [IW-1:0]        r_idx, c_idx, m_idx;
  logic [2*SW-1:0]      prod;
  logic                 prod_neg;
  logic [LW-1:0]        scat [MD];
  logic [MD-1:0]        mvalid;
  logic [LW-1:0]        mem_rd;
  logic                 mem_rd_ok;
  logic                 rd_ok;

  logic [NW-1:0]        quotient;
  logic [DW-1:0]        remainder;
  logic                 div_done;
  logic                 div_start;
  logic [NW-1:0]        dividend;
  logic [DW-1:0]        divisor;

  function automatic logic [SW-1:0] mag33(input logic signed [SW:0] v);
    logic [SW:0] n;
    n = -v;
    return v[SW] ? n[SW-1:0] : v[SW-1:0];
  endfunction

  // Status.
  logic [AW-1:0] sc_addr, rd_addr, mem_addr;
  logic          mem_rd_en;
  logic [SW:0]   n_val;

  assign sc_addr = AW'(int'(r_idx) * DIM + int'(c_idx));
  assign rd_addr = AW'(int'(row) * DIM + int'(col));
  assign n_val   = {1'b0, count} + 1'b1;

  always_comb begin
    sts.last_push = (mode == omsu_pkg::MODE_PUSH) && (element_index == 3'(DIM - 1));
    sts.is_read   = (mode == omsu_pkg::MODE_READ);
    sts.read_ok   = (int'(row) < DIM) && (int'(col) < DIM) && (count > CW'(DIM + 2));
    sts.scat_last = (r_idx == IW'(DIM - 1)) && (c_idx == IW'(DIM - 1));
    sts.mean_last = (m_idx == IW'(DIM - 1));
    sts.div_done  = div_done;
    sts.out_free  = !out_valid || out_ready;
  end

  // Divider operand selection.
  logic [SW-1:0]       dm;
  logic signed [LW-1:0] lam_cur;
  logic [LW-1:0]       lam_mag;

  assign dm      = mag33(diff[m_idx]);
  assign lam_cur = mem_rd_ok ? mem_rd : '0;
  assign lam_mag = lam_cur[LW-1] ? (~lam_cur + 1'b1) : lam_cur;
  assign div_start = cmd.scat_div | cmd.mean_div | cmd.rd_div;

  always_comb begin
    if (cmd.scat_div) begin
      dividend = prod;
      divisor  = DW'(n_val);
    end else if (cmd.mean_div) begin
      dividend = NW'({dm, 1'b0}) + NW'(n_val);
      divisor  = {n_val, 1'b0};
    end else begin
      dividend = lam_mag;
      divisor  = DW'(count - CW'(DIM + 2));
    end
  end

  omsu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dividend),
    .divisor   (divisor),
    .quotient  (quotient),
    .remainder (remainder),
    .done      (div_done)
  );

  // Scatter update arithmetic.
  logic [LW-1:0]       m_val;
  logic [48:0]         inc;
  logic signed [LW:0]  sum65;
  logic signed [LW-1:0] lam_new;

  assign m_val = prod - quotient;
  assign inc   = {1'b0, m_val[LW-1:16]} + 49'(m_val[15]);
  assign sum65 = prod_neg ? ({lam_cur[LW-1], lam_cur} - (LW+1)'(inc))
                          : ({lam_cur[LW-1], lam_cur} + (LW+1)'(inc));
  always_comb begin
    if (sum65[LW] != sum65[LW-1]) begin
      lam_new = sum65[LW] ? {1'b1, {(LW-1){1'b0}}} : {1'b0, {(LW-1){1'b1}}};
    end else begin
      lam_new = sum65[LW-1:0];
    end
  end

  // Mean update arithmetic.
  logic signed [SW+2:0] msum;
  logic signed [SW-1:0] mean_new;
  logic [SW+2:0]        mq;

  assign mq   = (SW+3)'(quotient[SW+1:0]);
  assign msum = diff[m_idx][SW] ? ((SW+3)'(mean[m_idx]) - $signed(mq))
                                : ((SW+3)'(mean[m_idx]) + $signed(mq));
  always_comb begin
    if (msum > (SW+3)'(32'sh7FFFFFFF)) begin
      mean_new = 32'sh7FFFFFFF;
    end else if (msum < (SW+3)'(-33'sh80000000)) begin
      mean_new = 32'sh80000000;
    end else begin
      mean_new = msum[SW-1:0];
    end
  end

  // Read result rounding.
  logic [LW-1:0] rq;
  logic [LW-1:0] rd_val;

  always_comb begin
    rq = quotient;
    if ({remainder, 1'b0} >= {1'b0, divisor}) begin
      rq = quotient + 1'b1;
    end
    if (lam_cur[LW-1]) begin
      rd_val = ~rq + 1'b1;
    end else if (rq[LW-1]) begin
      rd_val = {1'b0, {(LW-1){1'b1}}};
    end else begin
      rd_val = rq;
    end
  end

  // Sample buffer (undefined until written).
  always_ff @(posedge clk) begin
    if (cmd.accept && mode == omsu_pkg::MODE_PUSH && int'(element_index) < DIM) begin
      sample_buf[element_index[IW-1:0]] <= element_value;
    end
  end

  // Differences, product and indexes.
  always_ff @(posedge clk) begin
    if (cmd.latch_diff) begin
      for (int i = 0; i < DIM; i++) begin
        diff[i] <= (SW+1)'(sample_buf[i]) - (SW+1)'(mean[i]);
      end
      r_idx <= '0;
      c_idx <= '0;
      m_idx <= '0;
    end
    if (cmd.scat_mul) begin
      prod     <= mag33(diff[r_idx]) * mag33(diff[c_idx]);
      prod_neg <= diff[r_idx][SW] ^ diff[c_idx][SW];
    end
    if (cmd.scat_upd) begin
      if (c_idx == IW'(DIM - 1)) begin
        c_idx <= '0;
        r_idx <= r_idx + 1'b1;
      end else begin
        c_idx <= c_idx + 1'b1;
      end
    end
    if (cmd.mean_upd) begin
      m_idx <= m_idx + 1'b1;
    end
  end

  // Scatter memory, registered read.
  assign mem_rd_en = cmd.scat_mul | (cmd.accept & sts.is_read);
  assign mem_addr  = cmd.scat_mul ? sc_addr : rd_addr;

  always_ff @(posedge clk) begin
    if (cmd.scat_upd) begin
      scat[sc_addr] <= lam_new;
    end
    if (mem_rd_en) begin
      mem_rd <= scat[mem_addr];
    end
  end

  // Control-like state with reset: count, mean, valid bits, output.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      mvalid    <= '0;
      mem_rd_ok <= 1'b0;
      rd_ok     <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < DIM; i++) begin
        mean[i] <= '0;
      end
    end else begin
      if (mem_rd_en) begin
        mem_rd_ok <= mvalid[mem_addr];
      end
      if (cmd.accept && mode == omsu_pkg::MODE_CLEAR) begin
        count  <= '0;
        mvalid <= '0;
        for (int i = 0; i < DIM; i++) begin
          mean[i] <= '0;
        end
      end
      if (cmd.accept && sts.is_read) begin
        rd_ok <= sts.read_ok;
      end
      if (cmd.scat_upd) begin
        mvalid[sc_addr] <= 1'b1;
      end
      if (cmd.mean_upd) begin
        mean[m_idx] <= mean_new;
      end
      if (cmd.count_inc && count != '1) begin
        count <= count + 1'b1;
      end
      if (cmd.rd_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_out) begin
      variance_value <= rd_ok ? rd_val : '0;
      variance_valid <= rd_ok;
    end
  end

endmodule

// ===== rtl/omsu_ctrl.sv =====
// Controller state machine that sequences the datapath.
// Depends on omsu_pkg for the command and status types.
module omsu_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  omsu_pkg::sts_t  sts,
  output omsu_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_SMUL  = 4'd2;
  localparam logic [3:0] S_SDIV  = 4'd3;
  localparam logic [3:0] S_SWAIT = 4'd4;
  localparam logic [3:0] S_SUPD  = 4'd5;
  localparam logic [3:0] S_MDIV  = 4'd6;
  localparam logic [3:0] S_MWAIT = 4'd7;
  localparam logic [3:0] S_MUPD  = 4'd8;
  localparam logic [3:0] S_CNT   = 4'd9;
  localparam logic [3:0] S_RDIV  = 4'd10;
  localparam logic [3:0] S_RWAIT = 4'd11;
  localparam logic [3:0] S_ROUT  = 4'd12;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.last_push) begin
            state_next = S_DIFF;
          end else if (sts.is_read) begin
            state_next = sts.read_ok ? S_RDIV : S_ROUT;
          end
        end
      end
      S_DIFF: begin
        cmd.latch_diff = 1'b1;
        state_next     = S_SMUL;
      end
      S_SMUL: begin
        cmd.scat_mul = 1'b1;
        state_next   = S_SDIV;
      end
      S_SDIV: begin
        cmd.scat_div = 1'b1;
        state_next   = S_SWAIT;
      end
      S_SWAIT: begin
        if (sts.div_done) state_next = S_SUPD;
      end
      S_SUPD: begin
        cmd.scat_upd = 1'b1;
        state_next   = sts.scat_last ? S_MDIV : S_SMUL;
      end
      S_MDIV: begin
        cmd.mean_div = 1'b1;
        state_next   = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts.div_done) state_next = S_MUPD;
      end
      S_MUPD: begin
        cmd.mean_upd = 1'b1;
        state_next   = sts.mean_last ? S_CNT : S_MDIV;
      end
      S_CNT: begin
        cmd.count_inc = 1'b1;
        state_next    = S_IDLE;
      end
      S_RDIV: begin
        cmd.rd_div = 1'b1;
        state_next = S_RWAIT;
      end
      S_RWAIT: begin
        if (sts.div_done) state_next = S_ROUT;
      end
      S_ROUT: begin
        if (sts.out_free) begin
          cmd.rd_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/online_mean_scatter_update_unit.sv =====
// Top level of the online mean and scatter unit (running covariance).
// Depends on omsu_pkg, omsu_ctrl, omsu_dp and assert_macros.svh.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   input   | in        | in_valid / in_ready  | mode, element_index, element_value,
//           |           |                      | row, col
//   output  | out       | out_valid / out_ready| variance_value, variance_valid
//
// A push of a component other than the last, a clear, an ignored mode and
// an out-of-range push leave the unit idle and ready for the next item. The
// push that completes a vector occupies the unit through the scatter and
// mean update sequence; the shared 64-step radix-2 divider is used once
// per scatter entry and once per mean component.
// A valid variance read passes through the divider; an invalid one does not.
// Reset is synchronous and clears the count, mean and scatter valid bits.
// A result waiting in the output register blocks only the next read's
// final step; pushes and clears go on while it waits.
`include "assert_macros.svh"

module online_mean_scatter_update_unit #(
  parameter int DIM = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic [2:0]          element_index,
  input  logic signed [31:0]  element_value,
  input  logic [2:0]          row,
  input  logic [2:0]          col,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [63:0]  variance_value,
  output logic                variance_valid
);

  omsu_pkg::cmd_t cmd;
  omsu_pkg::sts_t sts;

  // The controller only steps the sequence; all arithmetic and storage
  // sit in the datapath.
  omsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  omsu_dp #(
    .DIM (DIM)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .mode           (mode),
    .element_index  (element_index),
    .element_value  (element_value),
    .row            (row),
    .col            (col),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .variance_value (variance_value),
    .variance_valid (variance_valid)
  );

  // A read keeps the unit busy in the cycle after it is taken.
  `OMSU_ASSERT_NEXT(a_read_busy, clk, rst, in_valid && in_ready && mode == omsu_pkg::MODE_READ, !in_ready)
  // The item that completes a vector starts the update sequence.
  `OMSU_ASSERT_NEXT(a_last_busy, clk, rst, in_valid && in_ready && mode == omsu_pkg::MODE_PUSH && element_index == 3'(DIM - 1), !in_ready)
  // A new result only appears at the end of a read sequence.
  `OMSU_ASSERT_IMPL(a_out_seq, clk, rst, $rose(out_valid), $past(!in_ready))

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for online_mean_scatter_update_unit: running mean,
// scatter matrix and variance reads, checked against an in-bench predictor.
// Depends on omsu_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module tb_top;

  localparam int DIM = 4;
  localparam int CLK_PERIOD = 8;
  // A completing push at DIM = 4, the longest driver gap and the longest
  // receiver stall are all covered by the bound below several times over.
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1600;
  localparam int ITEM_GOAL = 1350;
  // Mode 3 has no meaning in the unit and is dropped without a result.
  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]         op;
    logic [2:0]         idx;
    logic signed [31:0] value;
    logic [2:0]         r;
    logic [2:0]         c;
  } request_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               ok;
  } variance_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         mode;
  logic [2:0]         element_index;
  logic signed [31:0] element_value;
  logic [2:0]         row;
  logic [2:0]         col;
  logic               out_valid;
  logic               out_ready;
  logic signed [63:0] variance_value;
  logic               variance_valid;

  online_mean_scatter_update_unit #(.DIM(DIM)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .element_index(element_index), .element_value(element_value),
    .row(row), .col(col),
    .out_valid(out_valid), .out_ready(out_ready),
    .variance_value(variance_value), .variance_valid(variance_valid)
  );

  // Predictor state: the statistics as the unit should hold them.
  logic signed [31:0] comp_buf [DIM];
  logic signed [31:0] mean_est [DIM];
  logic signed [63:0] scatter  [DIM*DIM];
  logic [31:0]        vec_count;

  request_t  pending_requests [$];
  variance_t expected_variances [$];

  int errors = 0;
  int vectors_done = 0;
  int reads_valid = 0;
  int reads_invalid = 0;
  int clears_done = 0;
  int idle_cycles = 0;
  bit steady_in = 0;
  bit steady_out = 0;

  initial begin
    clk = 0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic [63:0] magnitude(logic signed [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic void clear_statistics();
    for (int i = 0; i < DIM; i++) mean_est[i] = '0;
    for (int i = 0; i < DIM*DIM; i++) scatter[i] = '0;
    vec_count = '0;
  endfunction

  // Folds the buffered vector into mean and scatter, using the count of
  // vectors seen before it; the scatter uses the deviation from the old mean.
  function automatic void fold_vector();
    logic signed [63:0] dev [DIM];
    logic [63:0]        n, p, m, inc, q;
    logic signed [64:0] acc;
    logic signed [63:0] sum;
    n = {32'd0, vec_count} + 64'd1;
    for (int i = 0; i < DIM; i++)
      dev[i] = 64'(comp_buf[i]) - 64'(mean_est[i]);
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        p = magnitude(dev[r]) * magnitude(dev[c]);
        m = p - p / n;
        inc = (m >> 16) + ((m >> 15) & 64'd1);
        if (dev[r][63] == dev[c][63])
          acc = 65'(scatter[r*DIM+c]) + $signed({1'b0, inc});
        else
          acc = 65'(scatter[r*DIM+c]) - $signed({1'b0, inc});
        if (acc > 65'(S64_MAX)) scatter[r*DIM+c] = S64_MAX;
        else if (acc < 65'(S64_MIN)) scatter[r*DIM+c] = S64_MIN;
        else scatter[r*DIM+c] = acc[63:0];
      end
    end
    for (int i = 0; i < DIM; i++) begin
      q = (2 * magnitude(dev[i]) + n) / (2 * n);
      sum = 64'(mean_est[i]) + (dev[i][63] ? -$signed(q) : $signed(q));
      if (sum > 64'sd2147483647) mean_est[i] = 32'sh7FFF_FFFF;
      else if (sum < -64'sd2147483648) mean_est[i] = 32'sh8000_0000;
      else mean_est[i] = sum[31:0];
    end
    if (vec_count != 32'hFFFF_FFFF) vec_count++;
    vectors_done++;
  endfunction

  // Applies one accepted item to the predictor and queues any result.
  function automatic void predict_item(request_t it);
    variance_t res;
    logic [63:0] div, mag, q, rem;
    logic signed [63:0] lam;
    case (it.op)
      omsu_pkg::MODE_PUSH: begin
        if (it.idx < DIM) begin
          comp_buf[it.idx] = it.value;
          if (it.idx == DIM - 1) fold_vector();
        end
      end
      omsu_pkg::MODE_CLEAR: begin
        clear_statistics();
        clears_done++;
      end
      omsu_pkg::MODE_READ: begin
        res = '0;
        if (it.r < DIM && it.c < DIM && {32'd0, vec_count} > DIM + 2) begin
          div = {32'd0, vec_count} - DIM - 2;
          lam = scatter[it.r*DIM+it.c];
          mag = magnitude(lam);
          q = mag / div;
          rem = mag % div;
          if (rem >= div - rem) q++;
          if (lam[63]) res.value = -q;
          else res.value = q[63] ? S64_MAX : q;
          res.ok = 1'b1;
          reads_valid++;
        end else begin
          reads_invalid++;
        end
        expected_variances.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // Sample component values: mostly moderate values near a common offset so
  // the statistics stay meaningful, with full-range and extreme values mixed in.
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 32'sh0003_0000 + $signed(32'($urandom_range(0, 2**21))) - 32'sh0010_0000;
    if (sel < 85) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0000_0000;
      3: return 32'shFFFF_FFFF;
      default: return 32'sh0001_0000;
    endcase
  endfunction

  function automatic request_t make_item(logic [1:0] op, logic [2:0] idx,
                                         logic signed [31:0] v, logic [2:0] r,
                                         logic [2:0] c);
    request_t it;
    it.op = op; it.idx = idx; it.value = v; it.r = r; it.c = c;
    return it;
  endfunction

  task automatic queue_vector(logic signed [31:0] v0, logic signed [31:0] v1,
                              logic signed [31:0] v2, logic signed [31:0] v3);
    logic signed [31:0] vals [DIM];
    vals = '{v0, v1, v2, v3};
    // Unused fields carry random bits; the unit must ignore them.
    for (int i = 0; i < DIM; i++)
      pending_requests.push_back(make_item(omsu_pkg::MODE_PUSH, 3'(i), vals[i],
                                           3'($urandom), 3'($urandom)));
  endtask

  task automatic queue_read(logic [2:0] r, logic [2:0] c);
    pending_requests.push_back(make_item(omsu_pkg::MODE_READ, 3'($urandom), $urandom,
                                         r, c));
  endtask

  // Stimulus: a directed opening, then random traffic that is mostly whole
  // vectors, with reads, a few clears and some noise in between.
  initial begin
    int counted;
    int sel;
    // Directed part. All components get written before any vector completes.
    queue_read(3'd0, 3'd0);                        // read with no samples
    queue_vector(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh0001_0000);
    queue_vector(32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 32'sh0);
    pending_requests.push_back(make_item(omsu_pkg::MODE_PUSH, 3'd7, 32'sh1234_5678,
                                         3'd0, 3'd0));
    pending_requests.push_back(make_item(omsu_pkg::MODE_PUSH, 3'd4, 32'shFFFF_FFFF,
                                         3'd7, 3'd7));
    pending_requests.push_back(make_item(MODE_IGNORED, 3'd3, 32'sh0, 3'd1, 3'd1));
    queue_read(3'd7, 3'd0);                        // row out of range
    queue_read(3'd1, 3'd4);                        // column out of range
    queue_read(3'd3, 3'd3);                        // still too few vectors
    pending_requests.push_back(make_item(omsu_pkg::MODE_CLEAR, 3'd7, 32'shFFFF_FFFF,
                                         3'd7, 3'd7));
    queue_read(3'd0, 3'd0);
    // The last component alone completes a vector; the buffer survives clears.
    pending_requests.push_back(make_item(omsu_pkg::MODE_PUSH, 3'd3, 32'sh0002_0000,
                                         3'd0, 3'd0));
    queue_vector(32'sh0001_0000, 32'shFFFF_0000, 32'sh0000_8000, 32'sh0);
    counted = 20;
    while (counted < ITEM_GOAL) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        queue_vector(pick_value(), pick_value(), pick_value(), pick_value());
        counted += DIM;
      end else if (sel < 85) begin
        if ($urandom_range(0, 9) < 8) queue_read(3'($urandom_range(0, DIM - 1)),
                                                 3'($urandom_range(0, DIM - 1)));
        else queue_read(3'($urandom), 3'($urandom));
        counted++;
      end else if (sel < 87) begin
        pending_requests.push_back(make_item(omsu_pkg::MODE_CLEAR, 3'($urandom),
                                             $urandom, 3'($urandom), 3'($urandom)));
        counted++;
      end else if (sel < 92) begin
        pending_requests.push_back(make_item(omsu_pkg::MODE_PUSH,
                                             3'($urandom_range(0, DIM - 1)),
                                             pick_value(), 3'($urandom),
                                             3'($urandom)));
        counted++;
      end else if (sel < 96) begin
        pending_requests.push_back(make_item(omsu_pkg::MODE_PUSH,
                                             3'($urandom_range(DIM, 7)),
                                             $urandom, 3'($urandom), 3'($urandom)));
      end else begin
        pending_requests.push_back(make_item(MODE_IGNORED, 3'($urandom), $urandom,
                                             3'($urandom), 3'($urandom)));
      end
    end
  end

  function automatic int pick_gap(bit steady);
    int sel;
    if (steady) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: presents queued items and feeds each accepted one to the predictor.
  int in_gap = 0;
  always @(posedge clk) begin
    request_t it;
    bit accepted;
    if (rst) begin
      in_valid <= 1'b0;
      mode <= omsu_pkg::MODE_PUSH;
      element_index <= '0;
      element_value <= '0;
      row <= '0;
      col <= '0;
      clear_statistics();
      for (int i = 0; i < DIM; i++) comp_buf[i] = '0;
    end else begin
      accepted = in_valid && in_ready;
      if (accepted) begin
        predict_item(make_item(mode, element_index, element_value, row, col));
        if ($urandom_range(0, 99) == 0) steady_in = !steady_in;
        in_gap = pick_gap(steady_in);
      end
      if (!in_valid || accepted) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          it = pending_requests.pop_front();
          mode <= it.op;
          element_index <= it.idx;
          element_value <= it.value;
          row <= it.r;
          col <= it.c;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each delivered variance against the oldest prediction
  // and stalls the output side at random.
  int out_gap = 0;
  always @(posedge clk) begin
    variance_t exp_v;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_variances.size() == 0) begin
          $display("%0t: unexpected result value=%0d valid=%0b", $time,
                   variance_value, variance_valid);
          errors++;
        end else begin
          exp_v = expected_variances.pop_front();
          if (variance_value !== exp_v.value) begin
            $display("%0t: variance_value mismatch: expected %0d, actual %0d",
                     $time, exp_v.value, variance_value);
            errors++;
          end
          if (variance_valid !== exp_v.ok) begin
            $display("%0t: variance_valid mismatch: expected %0b, actual %0b",
                     $time, exp_v.ok, variance_valid);
            errors++;
          end
        end
        if ($urandom_range(0, 49) == 0) steady_out = !steady_out;
        out_gap = pick_gap(steady_out);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_requests.size() > 0 || in_valid || expected_variances.size() > 0)
      @(posedge clk);
    // Let a trailing vector completion settle and catch any stray result.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_variances.size() > 0) begin
      $display("%0t: %0d predicted results never arrived", $time,
               expected_variances.size());
      errors++;
    end
    $display("Covered %0d completed vectors, %0d clears, %0d valid and %0d invalid reads.",
             vectors_done, clears_done, reads_valid, reads_invalid);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
